@@ rtl/olst_pkg.sv @@
// ----------------------------------------------------------------------------
// olst_pkg
// Shared types and codes for the ordered list store: transaction payloads,
// operation and status codes, and the control group broadcast to the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package olst_pkg;

   // Operation codes carried in the func field.
   localparam logic [1:0] FUNC_APPEND = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_READ   = 2'd2;
   localparam logic [1:0] FUNC_WRITE  = 2'd3;

   // Status codes returned with every result.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_RANGE     = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [3:0]  index;
      logic [31:0] value;
   } olst_req_type;

   typedef struct packed {
      logic [31:0] read_value;
      logic [3:0]  position;
      logic [1:0]  status;
      logic [4:0]  entry_count;
   } olst_rsp_type;

   // Qualified commands broadcast along the row of cells.
   typedef struct packed {
      logic append_go;
      logic remove;
      logic write_go;
   } olst_ctl_type;

endpackage

`default_nettype wire

@@ rtl/olst_cell.sv @@
// ----------------------------------------------------------------------------
// olst_cell
// One slot of the list. Holds one entry, compares it against the search
// value, passes the first-match flag and position to its upper neighbour and
// takes its upper neighbour's entry when the tail closes up after a removal.
// ----------------------------------------------------------------------------
`default_nettype none

module olst_cell #(
   parameter int POS   = 0,
   parameter int EW    = 32,
   parameter int CNT_W = 5,
   parameter int CW    = 5,
   parameter int POS_W = 4
) (
   input  wire                       clock,
   input  olst_pkg::olst_ctl_type    ctl,
   input  wire  [EW-1:0]             value_in,
   input  wire  [CNT_W-1:0]          count_in,
   input  wire  [CW-1:0]             index_in,
   input  wire  [EW-1:0]             next_entry,
   input  wire                       hit_in,
   input  wire  [POS_W-1:0]          pos_in,
   output logic [EW-1:0]             entry,
   output logic                      hit_out,
   output logic [POS_W-1:0]          pos_out
);
   import olst_pkg::*;

   logic [EW-1:0] entry_ff;
   logic [EW-1:0] entry_in;
   logic          live;
   logic          match;

   always_comb begin
      live    = CNT_W'(POS) < count_in;
      match   = ctl.remove && live && (entry_ff == value_in);
      hit_out = hit_in || match;
      // The lowest matching cell stamps its own position; cells above keep it.
      pos_out = hit_in ? pos_in : POS_W'(POS);

      entry_in = entry_ff;
      if (hit_out && live) begin
         entry_in = next_entry;
      end else if (ctl.append_go && (count_in == CNT_W'(POS))) begin
         entry_in = value_in;
      end else if (ctl.write_go && (index_in == CW'(POS))) begin
         entry_in = value_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

@@ rtl/ordered_list_store.sv @@
// ----------------------------------------------------------------------------
// ordered_list_store
// Fixed-capacity ordered list with append, remove-first-match, read at index
// and write at index, built as a row of slot cells with a live entry count.
// ----------------------------------------------------------------------------
//
//  channel   ports                         handshake
//  -------   ---------------------------   ------------------------------
//  request   start, busy, req_item         taken when start and not busy
//  result    rsp_valid, rsp_item           one-cycle strobe, no back-pressure
//
// Every transaction is worked when it is accepted: the row of cells
// compares, shifts and writes in the cycle of acceptance, and the result is
// registered and presented on the following cycle. busy is never raised, so
// a new transaction may be accepted every cycle. The receiver cannot stall.
// Reset clears the entry count and the result strobe; the slot contents are
// left as they are, since no operation can observe a slot beyond the count.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_store #(
   parameter int CAPACITY    = 16,
   parameter int ENTRY_WIDTH = 32
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   output logic                    busy,
   input  olst_pkg::olst_req_type  req_item,
   output logic                    rsp_valid,
   output olst_pkg::olst_rsp_type  rsp_item
);
   import olst_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int POS_W = $clog2(CAPACITY);
   localparam int CW    = (CNT_W > 4) ? CNT_W : 4;

   // Live entry count and registered result.
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              rsp_valid_ff;
   olst_rsp_type      rsp_ff;
   olst_rsp_type      rsp_in;

   logic              accept;
   logic              full;
   logic              in_range;
   logic [CW-1:0]     idx_ext;
   logic [ENTRY_WIDTH+31:0] value_wide;
   logic [ENTRY_WIDTH-1:0]  value_ent;
   logic [ENTRY_WIDTH+31:0] read_wide;
   logic [ENTRY_WIDTH-1:0]  read_ent;
   logic [POS_W+3:0]  match_pos_wide;
   logic [CNT_W+4:0]  count_wide;
   olst_ctl_type      ctl;

   // Row of cells and the chains that run through it.
   logic [ENTRY_WIDTH-1:0] ent_w  [CAPACITY];
   logic [ENTRY_WIDTH-1:0] next_w [CAPACITY];
   logic                   hit_w  [CAPACITY+1];
   logic [POS_W-1:0]       pos_w  [CAPACITY+1];

   // All work fits in the cycle of acceptance, so the block is never busy.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      // The incoming value is cut to the entry width before it is stored or
      // compared; wider entries are zero-extended.
      value_wide = {{ENTRY_WIDTH{1'b0}}, req_item.value};
      value_ent  = value_wide[ENTRY_WIDTH-1:0];
      idx_ext    = CW'(req_item.index);
      full       = count_ff == CNT_W'(CAPACITY);
      in_range   = idx_ext < CW'(count_ff);

      ctl.append_go = accept && (req_item.func == FUNC_APPEND) && !full;
      ctl.remove    = accept && (req_item.func == FUNC_REMOVE);
      ctl.write_go  = accept && (req_item.func == FUNC_WRITE) && in_range;
   end

   assign hit_w[0] = 1'b0;
   assign pos_w[0] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      // The top slot has no upper neighbour; it keeps its own entry when the tail closes up.
      if (i == CAPACITY - 1) begin : g_top
         assign next_w[i] = ent_w[i];
      end else begin : g_mid
         assign next_w[i] = ent_w[i+1];
      end

      olst_cell #(
         .POS   (i),
         .EW    (ENTRY_WIDTH),
         .CNT_W (CNT_W),
         .CW    (CW),
         .POS_W (POS_W)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .value_in   (value_ent),
         .count_in   (count_ff),
         .index_in   (idx_ext),
         .next_entry (next_w[i]),
         .hit_in     (hit_w[i]),
         .pos_in     (pos_w[i]),
         .entry      (ent_w[i]),
         .hit_out    (hit_w[i+1]),
         .pos_out    (pos_w[i+1])
      );
   end

   always_comb begin
      // A read index is only used once it is known to be inside the list.
      read_ent       = ent_w[idx_ext[POS_W-1:0]];
      read_wide      = {32'b0, read_ent};
      match_pos_wide = {4'b0, pos_w[CAPACITY]};

      count_in = count_ff;
      rsp_in   = '0;

      case (req_item.func)
         FUNC_APPEND: begin
            if (full) begin
               rsp_in.status = ST_FULL;
            end else begin
               count_wide      = {5'b0, count_ff};
               rsp_in.position = count_wide[3:0];
               rsp_in.status   = ST_OK;
               count_in        = count_ff + CNT_W'(1);
            end
         end
         FUNC_REMOVE: begin
            if (hit_w[CAPACITY]) begin
               rsp_in.position = match_pos_wide[3:0];
               rsp_in.status   = ST_OK;
               count_in        = count_ff - CNT_W'(1);
            end else begin
               rsp_in.status = ST_NOT_FOUND;
            end
         end
         FUNC_READ: begin
            if (in_range) begin
               rsp_in.read_value = read_wide[31:0];
               rsp_in.position   = req_item.index;
               rsp_in.status     = ST_OK;
            end else begin
               rsp_in.status = ST_RANGE;
            end
         end
         FUNC_WRITE: begin
            if (in_range) begin
               rsp_in.position = req_item.index;
               rsp_in.status   = ST_OK;
            end else begin
               rsp_in.status = ST_RANGE;
            end
         end
         default: begin
            rsp_in.status = ST_RANGE;
         end
      endcase

      // The reported count is taken after the operation.
      count_wide         = {5'b0, count_in};
      rsp_in.entry_count = count_wide[4:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef ASSERT_OFF
   // The count can never pass the number of slots.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count exceeds capacity");

   // Each accepted transaction yields exactly one result on the next cycle.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (rsp_valid_ff == $past(accept)))
      else $error("result strobe does not follow the accepted transaction");

   // A refused append is only reported while the list is full.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status == ST_FULL)) |-> full)
      else $error("list full reported with free slots");
`endif

endmodule

`default_nettype wire
